@@ src/mexp_pkg.sv @@
`timescale 1ns / 1ps

package mexp_pkg;

  // Operand width of the datapath
  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_BIT,
    ST_MUL,
    ST_SQR,
    ST_FINISH
  } state_t;

  // Request to the modular multiply unit
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
    word_t m;
  } mm_req_t;

  // Response from the modular multiply unit
  typedef struct packed {
    logic  busy;
    logic  done;
    word_t prod;
  } mm_rsp_t;

endpackage

@@ src/mexp_ifs.sv @@
`timescale 1ns / 1ps

// Input channel: one beat carries base, exponent and modulus
interface mexp_in_if;
  logic                 valid;
  logic                 ready;
  logic [mexp_pkg::WORD_BITS-1:0] base;
  logic [mexp_pkg::WORD_BITS-1:0] exponent;
  logic [mexp_pkg::WORD_BITS-1:0] modulus;

  modport source (output valid, output base, output exponent, output modulus, input ready);
  modport sink   (input valid, input base, input exponent, input modulus, output ready);
endinterface

// Result channel: one beat carries the power and the error flag
interface mexp_out_if;
  logic                 valid;
  logic                 ready;
  logic [mexp_pkg::WORD_BITS-1:0] power_result;
  logic                 bad_modulus;

  modport source (output valid, output power_result, output bad_modulus, input ready);
  modport sink   (input valid, input power_result, input bad_modulus, output ready);
endinterface

@@ src/mexp_mulmod.sv @@
`timescale 1ns / 1ps

// Bit-serial (a * b) mod m: one multiplier bit per cycle, MSB first.
// Requires a < m (or m == 1) and m != 0.
module mexp_mulmod (
  input  logic              clk,
  input  logic              rst_n,
  input  mexp_pkg::mm_req_t req,
  output mexp_pkg::mm_rsp_t rsp
);

  mexp_pkg::word_t             r_r, a_r, b_r, m_r;
  mexp_pkg::word_t             r_nxt;
  logic [mexp_pkg::CNT_W-1:0] cnt_r;
  logic                        busy_r, done_r;

  // (x + y) mod m for x, y < m, without overflow
  function automatic mexp_pkg::word_t add_mod(input mexp_pkg::word_t x,
                                              input mexp_pkg::word_t y,
                                              input mexp_pkg::word_t m);
    mexp_pkg::word_t gap;
    gap = m - y;
    if (x >= gap) begin
      add_mod = x - gap;
    end else begin
      add_mod = x + y;
    end
  endfunction

  // Double, then add a when the current multiplier bit is set
  always_comb begin
    r_nxt = add_mod(r_r, r_r, m_r);
    if (b_r[mexp_pkg::WORD_BITS-1]) begin
      r_nxt = add_mod(r_nxt, a_r, m_r);
    end
  end

  // Control: run WORD_BITS steps, then pulse done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= mexp_pkg::CNT_W'(mexp_pkg::WORD_BITS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then step the accumulator
  always_ff @(posedge clk) begin
    if (req.start) begin
      r_r <= '0;
      a_r <= req.a;
      b_r <= req.b;
      m_r <= req.m;
    end else if (busy_r) begin
      r_r <= r_nxt;
      b_r <= b_r << 1;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.prod = r_r;

  // Accumulator stays reduced during a product
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (r_r < m_r))
    else $error("accumulator left the residue range");

  // Done follows the last step of a running product
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && $past(cnt_r) == '0))
    else $error("done without a finished product");

endmodule

@@ src/modular_exponentiation.sv @@
`timescale 1ns / 1ps

// Modular exponentiation, base^exponent mod modulus, 32-bit unsigned.
// in_chan (sink): one beat carries base, exponent and modulus; ready is high
// only while the sequencer is idle, so one item is worked on at a time.
// out_chan (source): one beat per item with power_result and bad_modulus.
// A zero exponent gives 1 (even for modulus 1); a zero modulus gives 0 with
// bad_modulus set. Every modular product runs on one shared bit-serial
// multiply unit at one multiplier bit per cycle. An item takes the base
// reduction plus, for each exponent bit up to the highest set bit, a multiply
// into the running result when the bit is set and then the squaring, then
// the finish state, which loads the result into the output register. The
// unit's bit loop sets the item rate.
// Reset (synchronous, active low) drops any item in flight and any pending
// result. A stalled receiver holds the result in the output register; the
// block still takes and computes the next item, then waits to hand it over.
module modular_exponentiation (
  input  logic         clk,
  input  logic         rst_n,
  mexp_in_if.sink      in_chan,
  mexp_out_if.source   out_chan
);

  mexp_pkg::state_t  state_r, state_nxt;
  mexp_pkg::mm_req_t mm_req;
  mexp_pkg::mm_rsp_t mm_rsp;

  mexp_pkg::word_t e_r, m_r, sq_r, res_r;
  logic            bad_r;
  logic            out_valid_r, out_bad_r;
  mexp_pkg::word_t out_res_r;
  logic            in_take, out_load;

  mexp_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = (in_chan.modulus == '0) ? mexp_pkg::ST_FINISH : mexp_pkg::ST_RED;
        end
      end
      mexp_pkg::ST_RED: begin
        if (mm_rsp.done) state_nxt = mexp_pkg::ST_BIT;
      end
      mexp_pkg::ST_BIT: begin
        if (e_r == '0) begin
          state_nxt = mexp_pkg::ST_FINISH;
        end else if (e_r[0]) begin
          state_nxt = mexp_pkg::ST_MUL;
        end else begin
          state_nxt = mexp_pkg::ST_SQR;
        end
      end
      mexp_pkg::ST_MUL: begin
        if (mm_rsp.done) state_nxt = mexp_pkg::ST_SQR;
      end
      mexp_pkg::ST_SQR: begin
        if (mm_rsp.done) state_nxt = mexp_pkg::ST_BIT;
      end
      mexp_pkg::ST_FINISH: begin
        if (!out_valid_r || out_chan.ready) state_nxt = mexp_pkg::ST_IDLE;
      end
      default: state_nxt = mexp_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and multiply unit requests
  always_comb begin
    in_take      = 1'b0;
    out_load     = 1'b0;
    mm_req.start = 1'b0;
    mm_req.a     = sq_r;
    mm_req.b     = sq_r;
    mm_req.m     = m_r;
    unique case (state_r)
      mexp_pkg::ST_IDLE: begin
        // Reduce the base as 1 * base mod modulus
        in_take      = in_chan.valid;
        mm_req.start = in_chan.valid && (in_chan.modulus != '0);
        mm_req.a     = mexp_pkg::word_t'(1);
        mm_req.b     = in_chan.base;
        mm_req.m     = in_chan.modulus;
      end
      mexp_pkg::ST_BIT: begin
        mm_req.start = (e_r != '0);
        if (e_r[0]) mm_req.b = res_r;
      end
      mexp_pkg::ST_MUL: begin
        mm_req.start = mm_rsp.done;
      end
      mexp_pkg::ST_FINISH: begin
        out_load = !out_valid_r || out_chan.ready;
      end
      default: begin
      end
    endcase
  end

  assign in_chan.ready = (state_r == mexp_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mexp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers: exponent, modulus, bad-modulus flag, square and running result
  always_ff @(posedge clk) begin
    if (in_take) begin
      e_r   <= in_chan.exponent;
      m_r   <= in_chan.modulus;
      bad_r <= (in_chan.modulus == '0);
      res_r <= (in_chan.modulus == '0) ? '0 : mexp_pkg::word_t'(1);
    end else if (mm_rsp.done) begin
      unique case (state_r)
        mexp_pkg::ST_RED: sq_r  <= mm_rsp.prod;
        mexp_pkg::ST_MUL: res_r <= mm_rsp.prod;
        mexp_pkg::ST_SQR: begin
          sq_r <= mm_rsp.prod;
          e_r  <= e_r >> 1;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: hold the beat until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= res_r;
      out_bad_r <= bad_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.power_result = out_res_r;
  assign out_chan.bad_modulus  = out_bad_r;

  // Never restart the multiply unit mid-product
  a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    mm_req.start |-> !mm_rsp.busy)
    else $error("multiply started while unit busy");

  // A product completes only where the sequencer waits for one
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.done |-> (state_r == mexp_pkg::ST_RED || state_r == mexp_pkg::ST_MUL ||
                     state_r == mexp_pkg::ST_SQR))
    else $error("unexpected product from multiply unit");

  // A flagged modulus always comes with a zero result
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> (out_res_r == '0))
    else $error("bad modulus with nonzero result");

  // A result beat is loaded only when the output slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_chan.ready))
    else $error("pending result overwritten");

endmodule
